// ----- rtl/core/bmhq_pkg.sv -----
// Binary min-heap queue: shared widths, operation and status codes, sequencer states.
// No dependencies; imported by every other file of the block but bmhq_ram.
package bmhq_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int KEY_W    = 32;

  localparam logic [KEY_W-1:0] KEY_MIN   = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic [KEY_W-1:0] KEY_EMPTY = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] KEY_ZERO  = {KEY_W{1'b0}};
  localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_DECREASE = 2'd2,
    OP_DELETE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_TK_RD0,
    S_TK_RDL,
    S_TK_LAST,
    S_DN_L,
    S_DN_LW,
    S_DN_RW,
    S_FIN
  } state_t;

endpackage

// ----- rtl/core/bmhq_if.sv -----
// Binary min-heap queue: request, response and capacity configuration channels.
// Depends on bmhq_pkg for widths and codes.
interface bmhq_req_if import bmhq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  op_t                     operation;
  logic signed [KEY_W-1:0] key;
  logic [ADDR_W-1:0]       index;

  modport source (output valid, output operation, output key, output index, input ready);
  modport sink   (input valid, input operation, input key, input index, output ready);
endinterface

interface bmhq_rsp_if import bmhq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic signed [KEY_W-1:0] value;
  logic [CNT_W-1:0]        count;

  modport source (output valid, output status, output value, output count, input ready);
  modport sink   (input valid, input status, input value, input count, output ready);
endinterface

interface bmhq_cfg_if import bmhq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/bmhq_ram.sv -----
// Binary min-heap queue: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/binary_min_heap_queue.sv -----
// Binary min-heap queue of signed keys: one shared comparator under a small sequencer.
// Depends on bmhq_pkg, the channel interfaces in bmhq_if and bmhq_ram.
//
//   channel | role   | payload                       | transaction
//   req     | sink   | operation, key, index         | valid & ready
//   rsp     | source | status, value, count          | valid & ready
//   cfg     | sink   | data (capacity in use)        | valid & ready, always ready
//
// One request at a time; ready is high only while the sequencer is idle.
// Insert and decrease-key climb toward the root level by level; extract moves the last key to the root
// and sifts it down level by level; delete-key climbs to the root as the minimum key, then works as extract.
// Each level takes its reads through the single RAM read port; only extract reports the removed key.
// Synchronous reset empties the heap and restores full capacity; no clearing pass.
// A waiting response holds the next finished transaction in its final state.
module binary_min_heap_queue import bmhq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  bmhq_req_if.sink    req,
  bmhq_rsp_if.source  rsp,
  bmhq_cfg_if.sink    cfg
);

  state_t            state, state_next;
  op_t               op_reg, op_reg_next;
  logic [KEY_W-1:0]  cur, cur_next;
  logic [ADDR_W-1:0] pos, pos_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  cap;
  status_t           status_reg, status_reg_next;
  logic [KEY_W-1:0]  value_reg, value_reg_next;
  logic [KEY_W-1:0]  best_key, best_key_next;
  logic              best_moved, best_moved_next;
  logic              rsp_valid;
  status_t           rsp_status;
  logic [KEY_W-1:0]  rsp_value;
  logic [CNT_W-1:0]  rsp_count;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [KEY_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [KEY_W-1:0]  ram_rdata;

  logic [KEY_W-1:0]  cmp_a, cmp_b;
  logic              less;
  logic [ADDR_W-1:0] parent;
  logic [CNT_W-1:0]  left_idx;
  logic [CNT_W:0]    right_idx;
  logic              left_ok, right_ok, take_r;
  logic [CNT_W-1:0]  eff_cap;
  logic              fin_free;
  logic              accept;

  bmhq_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign less      = $signed(cmp_a) < $signed(cmp_b);
  assign parent    = (pos - ADDR_W'(1)) >> 1;
  assign left_idx  = {pos, 1'b1};
  assign right_idx = {1'b0, left_idx} + (CNT_W+1)'(1);
  assign left_ok   = left_idx < count;
  assign right_ok  = right_idx < {1'b0, count};
  assign take_r    = right_ok && less;
  assign eff_cap   = (cap > CAP_MAX) ? CAP_MAX : cap;
  assign fin_free  = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign cfg.ready  = 1'b1;
  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.value  = rsp_value;
  assign rsp.count  = rsp_count;

  always_comb begin
    state_next      = state;
    op_reg_next     = op_reg;
    cur_next        = cur;
    pos_next        = pos;
    count_next      = count;
    status_reg_next = status_reg;
    value_reg_next  = value_reg;
    best_key_next   = best_key;
    best_moved_next = best_moved;
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_reg_next     = req.operation;
          status_reg_next = ST_OK;
          value_reg_next  = KEY_ZERO;
          case (req.operation)
            OP_INSERT: begin
              if (count >= eff_cap) begin
                status_reg_next = ST_FULL;
                state_next      = S_FIN;
              end else begin
                cur_next   = req.key;
                pos_next   = count[ADDR_W-1:0];
                count_next = count + CNT_W'(1);
                state_next = S_UP_RD;
              end
            end
            OP_EXTRACT: begin
              if (count == '0) begin
                status_reg_next = ST_EMPTY;
                value_reg_next  = KEY_EMPTY;
                state_next      = S_FIN;
              end else begin
                state_next = S_TK_RD0;
              end
            end
            default: begin
              if (CNT_W'(req.index) >= count) begin
                status_reg_next = ST_BAD_INDEX;
                state_next      = S_FIN;
              end else begin
                cur_next   = (req.operation == OP_DELETE) ? KEY_MIN : req.key;
                pos_next   = req.index;
                state_next = S_UP_RD;
              end
            end
          endcase
        end
      end
      S_UP_RD: begin
        if (pos == '0) begin
          state_next = (op_reg == OP_DELETE) ? S_TK_RD0 : S_FIN;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (less) begin
          pos_next   = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = (op_reg == OP_DELETE) ? S_TK_RD0 : S_FIN;
        end
      end
      S_TK_RD0: begin
        count_next = count - CNT_W'(1);
        state_next = S_TK_RDL;
      end
      S_TK_RDL: begin
        if (op_reg == OP_EXTRACT) begin
          value_reg_next = ram_rdata;
        end
        state_next = S_TK_LAST;
      end
      S_TK_LAST: begin
        cur_next   = ram_rdata;
        pos_next   = '0;
        state_next = S_DN_L;
      end
      S_DN_L: begin
        state_next = left_ok ? S_DN_LW : S_FIN;
      end
      S_DN_LW: begin
        best_key_next   = less ? ram_rdata : cur;
        best_moved_next = less;
        state_next      = S_DN_RW;
      end
      S_DN_RW: begin
        if (best_moved || take_r) begin
          pos_next   = take_r ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
          state_next = S_DN_L;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req.ready = (state == S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = cur;
    ram_raddr = '0;
    cmp_a     = cur;
    cmp_b     = ram_rdata;
    case (state)
      S_UP_RD: begin
        ram_raddr = parent;
        ram_we    = (pos == '0);
      end
      S_UP_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = less ? ram_rdata : cur;
      end
      S_TK_RD0: begin
        ram_raddr = '0;
      end
      S_TK_RDL: begin
        ram_raddr = count[ADDR_W-1:0];
      end
      S_DN_L: begin
        ram_raddr = left_idx[ADDR_W-1:0];
        ram_we    = !left_ok;
      end
      S_DN_LW: begin
        ram_raddr = right_idx[ADDR_W-1:0];
        cmp_a     = ram_rdata;
        cmp_b     = cur;
      end
      S_DN_RW: begin
        cmp_a     = ram_rdata;
        cmp_b     = best_key;
        ram_we    = 1'b1;
        ram_wdata = take_r ? ram_rdata : (best_moved ? best_key : cur);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      cap        <= CAP_MAX;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg.valid && cfg.ready) begin
        cap <= cfg.data;
      end
      if (state == S_FIN && fin_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_reg     <= op_reg_next;
    cur        <= cur_next;
    pos        <= pos_next;
    status_reg <= status_reg_next;
    value_reg  <= value_reg_next;
    best_key   <= best_key_next;
    best_moved <= best_moved_next;
    if (state == S_FIN && fin_free) begin
      rsp_status <= status_reg;
      rsp_value  <= value_reg;
      rsp_count  <= count;
    end
  end

endmodule

// ----- rtl/core/bmhq_checker.sv -----
// Binary min-heap queue: port-level checks over time, bound to the top level.
// Depends on bmhq_pkg and binary_min_heap_queue.
module bmhq_checker import bmhq_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [1:0]       rsp_status,
  input logic [KEY_W-1:0] rsp_value,
  input logic [CNT_W-1:0] rsp_count
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_value)
      && $stable(rsp_count))
    else $error("response changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while a transaction is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_count <= CAP_MAX)
    else $error("count above capacity");

  a_empty_reply: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_EMPTY |-> rsp_value == KEY_EMPTY && rsp_count == '0)
    else $error("empty reply malformed");

  a_error_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_BAD_INDEX) |-> rsp_value == KEY_ZERO)
    else $error("error reply carries a value");

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_value  (rsp.value),
  .rsp_count  (rsp.count)
);
